/* sv/pbcs_pkg.sv */
package pbcs_pkg;

    // Default table size and fixed field widths
    localparam int SLOTS_DEF  = 8;
    localparam int SLOT_W     = 3;
    localparam int TYPE_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int MASK_REGS  = 4;

    // Command codes
    localparam logic [2:0] KIND_ADD    = 3'd0;
    localparam logic [2:0] KIND_MOVE   = 3'd1;
    localparam logic [2:0] KIND_DELETE = 3'd2;
    localparam logic [2:0] KIND_SCAN   = 3'd3;
    localparam logic [2:0] KIND_CLEAR  = 3'd4;

    // Mask register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_0_3   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_4_7   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_8_11  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_12_15 = 2'd3;

    typedef struct packed {
        logic [2:0]        kind;
        logic [SLOT_W-1:0] slot;
        logic signed [15:0] box_x;
        logic signed [15:0] box_y;
        logic [14:0]       box_w;
        logic [14:0]       box_h;
        logic [TYPE_W-1:0] box_type;
        logic              has_listener;
    } in_t;

    typedef struct packed {
        logic [SLOT_W-1:0] self_slot;
        logic [SLOT_W-1:0] other_slot;
        logic              is_collision;
        logic              table_full;
        logic              last;
    } out_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
    } box_t;

    typedef struct packed {
        logic              listener;
        logic [TYPE_W-1:0] typ;
    } kind_t;

endpackage

/* sv/pbcs_overlap.sv */
module pbcs_overlap
    import pbcs_pkg::*;
(
    input  box_t a,
    input  box_t b,
    output logic hit
);

    logic signed [16:0] a_right, a_bottom, b_right, b_bottom;
    logic signed [16:0] ax, ay, bx, by;

    // Extend edges and form far edges
    always_comb
    begin
        ax       = 17'(a.x);
        ay       = 17'(a.y);
        bx       = 17'(b.x);
        by       = 17'(b.y);
        a_right  = ax + $signed({2'b00, a.w});
        a_bottom = ay + $signed({2'b00, a.h});
        b_right  = bx + $signed({2'b00, b.w});
        b_bottom = by + $signed({2'b00, b.h});
    end

    // Strict overlap on both axes
    assign hit = (ax < b_right) && (bx < a_right) && (ay < b_bottom) && (by < a_bottom);

endmodule

/* sv/pbcs_table.sv */
module pbcs_table
    import pbcs_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
)
(
    input  logic             clk,
    input  logic             wr_box_en,
    input  logic             wr_kind_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  box_t             wr_box,
    input  kind_t            wr_kind,
    input  logic [IDX_W-1:0] rd_addr_a,
    input  logic [IDX_W-1:0] rd_addr_b,
    output box_t             rd_box_a,
    output box_t             rd_box_b,
    output kind_t            rd_kind_a,
    output kind_t            rd_kind_b
);

    box_t  box_mem  [SLOTS];
    kind_t kind_mem [SLOTS];

    // Write one entry per cycle
    always_ff @(posedge clk)
    begin
        if (wr_box_en)
        begin
            box_mem[wr_addr] <= wr_box;
        end
        if (wr_kind_en)
        begin
            kind_mem[wr_addr] <= wr_kind;
        end
    end

    // Registered reads at the pair addresses
    always_ff @(posedge clk)
    begin
        rd_box_a  <= box_mem[rd_addr_a];
        rd_box_b  <= box_mem[rd_addr_b];
        rd_kind_a <= kind_mem[rd_addr_a];
        rd_kind_b <= kind_mem[rd_addr_b];
    end

endmodule

/* sv/pairwise_box_collision_scan.sv */
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   in_data   (in_t: one command request)
// out       output     out_valid / out_stall out_data  (out_t: one result)
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data (type mask rows)
//
// A request is taken in idle, then executed in the next cycle; add, move, delete and
// clear finish there (add also needs the output register free). A scan walks slot pairs
// i<k over one shared overlap comparator reading the slot memory: a pair with a free
// slot is skipped in ST_PAIR, a used pair passes ST_PAIR and ST_CMP, and an overlapping
// pair then passes ST_REP_A and ST_REP_B (one per report direction, sent or not); the
// scan starts in ST_CMD and ends with the done item sent from ST_DONE.
// Reset (rst_n low) frees every slot and clears the masks; a stalled output holds the
// sequencer only in a state with a new result to send, until the pending result is taken.
module pairwise_box_collision_scan
    import pbcs_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_t                   in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_t                  out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] I_LAST = IDX_W'(SLOTS - 2);
    localparam logic [IDX_W-1:0] K_LAST = IDX_W'(SLOTS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_PAIR,
        ST_CMP,
        ST_REP_A,
        ST_REP_B,
        ST_DONE
    } state_t;

    state_t                state_reg, state_next;
    in_t                   req_reg, req_next;
    logic [IDX_W-1:0]      i_reg, i_next;
    logic [IDX_W-1:0]      k_reg, k_next;
    logic [SLOTS-1:0]      used_reg, used_next;
    logic [SLOTS-1:0]      marked_reg, marked_next;
    logic                  out_valid_reg, out_valid_next;
    out_t                  out_data_reg, out_data_next;
    logic [CFG_DATA_W-1:0] mask_reg [MASK_REGS];

    logic [MASK_REGS*CFG_DATA_W-1:0] mask_flat;
    logic                  out_free;
    logic                  free_found;
    logic [IDX_W-1:0]      free_idx;
    logic                  slot_ok;
    logic [IDX_W-1:0]      slot_idx;
    logic                  last_pair;
    logic [IDX_W-1:0]      adv_i, adv_k;
    logic                  hit;
    logic                  rep_a, rep_b;

    logic                  wr_box_en, wr_kind_en;
    logic [IDX_W-1:0]      wr_addr;
    box_t                  wr_box;
    kind_t                 wr_kind;
    box_t                  rd_box_a, rd_box_b;
    kind_t                 rd_kind_a, rd_kind_b;

    pbcs_table #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_table (
        .clk        (clk),
        .wr_box_en  (wr_box_en),
        .wr_kind_en (wr_kind_en),
        .wr_addr    (wr_addr),
        .wr_box     (wr_box),
        .wr_kind    (wr_kind),
        .rd_addr_a  (i_reg),
        .rd_addr_b  (k_reg),
        .rd_box_a   (rd_box_a),
        .rd_box_b   (rd_box_b),
        .rd_kind_a  (rd_kind_a),
        .rd_kind_b  (rd_kind_b)
    );

    pbcs_overlap u_overlap (
        .a   (rd_box_a),
        .b   (rd_box_b),
        .hit (hit)
    );

    // Handshake outputs
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Type mask registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < MASK_REGS; r++)
            begin
                mask_reg[r] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MASK_0_3:   mask_reg[0] <= cfg_data;
                CFG_MASK_4_7:   mask_reg[1] <= cfg_data;
                CFG_MASK_8_11:  mask_reg[2] <= cfg_data;
                CFG_MASK_12_15: mask_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign mask_flat = {mask_reg[3], mask_reg[2], mask_reg[1], mask_reg[0]};

    // Report rule for both directions of the current pair
    assign rep_a = rd_kind_a.listener && mask_flat[{rd_kind_a.typ, rd_kind_b.typ}];
    assign rep_b = rd_kind_b.listener && mask_flat[{rd_kind_b.typ, rd_kind_a.typ}];

    // Lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (!used_reg[s])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(s);
            end
        end
    end

    assign slot_ok  = (int'(req_reg.slot) < SLOTS);
    assign slot_idx = req_reg.slot[IDX_W-1:0];

    // Pair walk order
    assign last_pair = (i_reg == I_LAST) && (k_reg == K_LAST);
    always_comb
    begin
        if (k_reg == K_LAST)
        begin
            adv_i = i_reg + 1'b1;
            adv_k = IDX_W'(int'(i_reg) + 2);
        end
        else
        begin
            adv_i = i_reg;
            adv_k = k_reg + 1'b1;
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        used_next      = used_reg;
        marked_next    = marked_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        wr_box_en      = 1'b0;
        wr_kind_en     = 1'b0;
        wr_addr        = free_idx;
        wr_box         = '{x: req_reg.box_x, y: req_reg.box_y,
                           w: req_reg.box_w, h: req_reg.box_h};
        wr_kind        = '{listener: req_reg.has_listener, typ: req_reg.box_type};

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = in_data;
                    state_next = ST_CMD;
                end
            end

            ST_CMD:
            begin
                case (req_reg.kind)
                    KIND_ADD:
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = '0;
                            out_data_next.last = 1'b1;
                            if (free_found)
                            begin
                                wr_box_en  = 1'b1;
                                wr_kind_en = 1'b1;
                                used_next[free_idx]   = 1'b1;
                                marked_next[free_idx] = 1'b0;
                                out_data_next.self_slot = SLOT_W'(free_idx);
                            end
                            else
                            begin
                                out_data_next.table_full = 1'b1;
                            end
                            state_next = ST_IDLE;
                        end
                    end
                    KIND_MOVE:
                    begin
                        wr_addr    = slot_idx;
                        wr_box_en  = slot_ok;
                        state_next = ST_IDLE;
                    end
                    KIND_DELETE:
                    begin
                        if (slot_ok && used_reg[slot_idx])
                        begin
                            marked_next[slot_idx] = 1'b1;
                        end
                        state_next = ST_IDLE;
                    end
                    KIND_SCAN:
                    begin
                        used_next   = used_reg & ~marked_reg;
                        marked_next = '0;
                        i_next      = '0;
                        k_next      = IDX_W'(1);
                        state_next  = ST_PAIR;
                    end
                    KIND_CLEAR:
                    begin
                        used_next   = '0;
                        marked_next = '0;
                        state_next  = ST_IDLE;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            // Skip pairs with a free slot; otherwise wait for the read data
            ST_PAIR:
            begin
                if (used_reg[i_reg] && used_reg[k_reg])
                begin
                    state_next = ST_CMP;
                end
                else
                begin
                    i_next     = adv_i;
                    k_next     = adv_k;
                    state_next = last_pair ? ST_DONE : ST_PAIR;
                end
            end

            ST_CMP:
            begin
                if (hit)
                begin
                    state_next = ST_REP_A;
                end
                else
                begin
                    i_next     = adv_i;
                    k_next     = adv_k;
                    state_next = last_pair ? ST_DONE : ST_PAIR;
                end
            end

            // Report i to k
            ST_REP_A:
            begin
                if (!rep_a)
                begin
                    state_next = ST_REP_B;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{self_slot: SLOT_W'(i_reg), other_slot: SLOT_W'(k_reg),
                                       is_collision: 1'b1, table_full: 1'b0, last: 1'b0};
                    state_next     = ST_REP_B;
                end
            end

            // Report k to i, then advance
            ST_REP_B:
            begin
                if (!rep_b || out_free)
                begin
                    if (rep_b)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = '{self_slot: SLOT_W'(k_reg),
                                           other_slot: SLOT_W'(i_reg),
                                           is_collision: 1'b1, table_full: 1'b0,
                                           last: 1'b0};
                    end
                    i_next     = adv_i;
                    k_next     = adv_k;
                    state_next = last_pair ? ST_DONE : ST_PAIR;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next.last = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            k_reg         <= '0;
            used_reg      <= '0;
            marked_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            used_reg      <= used_next;
            marked_reg    <= marked_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        out_data_reg <= out_data_next;
    end

endmodule
